>>> rtl/core/rss_pkg.sv
// rss_pkg: shared widths, reset values, register codes and record types of the
// range scan segmenter; no dependencies
`default_nettype none

package rss_pkg;

    localparam int MAX_SAMPLES_DEF = 4096;
    localparam int MID_DEPTH_DEF   = 4;
    localparam int OUT_DEPTH_DEF   = 4;

    localparam int RANGE_W   = 16;
    localparam int SCAN_W    = 16;
    localparam int ID_W      = 13;
    localparam int ANGLE_W   = 28;
    localparam int STEP_W    = 16;
    localparam int IDX_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 16;

    localparam logic [RANGE_W-1:0] RANGE_LIMIT_RST = 16'd8000;
    localparam logic [RANGE_W-1:0] GAP_THRESH_RST  = 16'd1000;
    localparam logic [STEP_W-1:0]  ANGLE_STEP_RST  = 16'd18350;
    localparam logic [SCAN_W-1:0]  SCAN_CNT_RST    = 16'd1;
    localparam logic [ID_W-1:0]    ID_MAX          = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RANGE_LIMIT   = 2'd0,
        CFG_GAP_THRESHOLD = 2'd1,
        CFG_ANGLE_STEP    = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [RANGE_W-1:0] range_limit;
        logic [RANGE_W-1:0] gap_threshold;
    } front_cfg_t;

    // one result before the angle multiply
    typedef struct packed {
        logic [SCAN_W-1:0]  scan_number;
        logic [ID_W-1:0]    object_id;
        logic               object_valid;
        logic [IDX_W-1:0]   nearest_index;
        logic [RANGE_W-1:0] min_distance;
        logic               last_of_scan;
    } res_t;

    // one request from front to back: one or two results
    typedef struct packed {
        logic two;
        res_t first;
        res_t second;
    } seg_cmd_t;

    typedef struct packed {
        logic [SCAN_W-1:0]  scan_number;
        logic [ID_W-1:0]    object_id;
        logic               object_valid;
        logic [ANGLE_W-1:0] angle;
        logic [RANGE_W-1:0] min_distance;
        logic               last_of_scan;
    } out_t;

endpackage

`default_nettype wire

>>> rtl/core/rss_queue.sv
// rss_queue: small register fifo with combinational read of the oldest entry
// depends on nothing
`default_nettype none

module rss_queue #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       push,
    input  wire logic [W-1:0]               push_data,
    output logic                            full,
    input  wire logic                       pop,
    output logic [W-1:0]                    pop_data,
    output logic                            empty,
    output logic [$clog2(DEPTH+1)-1:0]      level
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LW = $clog2(DEPTH+1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH-1);
    localparam logic [LW-1:0] LVL_FULL = LW'(DEPTH);

    logic [W-1:0]  mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [LW-1:0] level_reg, level_next;
    logic          do_push, do_pop;

    assign full     = (level_reg == LVL_FULL);
    assign empty    = (level_reg == '0);
    assign level    = level_reg;
    assign pop_data = mem_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        level_next  = level_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            level_next = level_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            level_next = level_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/rss_front.sv
// rss_front: takes range samples, tracks the open object and issues result
// requests; depends on rss_pkg
`default_nettype none

module rss_front
    import rss_pkg::*;
#(
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire logic [RANGE_W-1:0] range_mm,
    input  wire logic               end_of_scan,
    input  wire front_cfg_t         cfg,
    input  wire logic               cmd_full,
    output logic                    cmd_push,
    output seg_cmd_t                cmd_data
);

    localparam int SW = $clog2(MAX_SAMPLES);
    localparam logic [SW-1:0] IDX_LAST = SW'(MAX_SAMPLES - 1);

    function automatic logic [ID_W-1:0] sat_inc(input logic [ID_W-1:0] v);
        sat_inc = (v == ID_MAX) ? v : v + 1'b1;
    endfunction

    logic [RANGE_W-1:0] prev_range_reg, prev_range_next;
    logic               prev_in_reg, prev_in_next;
    logic [SW-1:0]      sample_idx_reg, sample_idx_next;
    logic               open_reg, open_next;
    logic [RANGE_W-1:0] near_range_reg, near_range_next;
    logic [SW-1:0]      near_idx_reg, near_idx_next;
    logic [ID_W-1:0]    obj_cnt_reg, obj_cnt_next;
    logic [SCAN_W-1:0]  scan_cnt_reg, scan_cnt_next;

    logic               accept, in_range, join_obj, close_obj;
    logic [RANGE_W-1:0] diff;
    logic [ID_W-1:0]    cnt_after_close, eos_id;
    res_t               close_res, eos_res;

    assign accept = push && !cmd_full;

    always_comb
    begin
        in_range  = (range_mm != '0) && (range_mm < cfg.range_limit);
        diff      = (range_mm >= prev_range_reg) ? range_mm - prev_range_reg
                                                 : prev_range_reg - range_mm;
        join_obj  = open_reg && prev_in_reg && (diff < cfg.gap_threshold);
        close_obj = in_range && !join_obj && open_reg;

        open_next       = open_reg;
        near_range_next = near_range_reg;
        near_idx_next   = near_idx_reg;
        if (in_range)
        begin
            if (join_obj)
            begin
                if (range_mm < near_range_reg)
                begin
                    near_range_next = range_mm;
                    near_idx_next   = sample_idx_reg;
                end
            end
            else
            begin
                open_next       = 1'b1;
                near_range_next = range_mm;
                near_idx_next   = sample_idx_reg;
            end
        end

        cnt_after_close = close_obj ? sat_inc(obj_cnt_reg) : obj_cnt_reg;
        eos_id          = open_next ? sat_inc(cnt_after_close) : '0;

        close_res.scan_number   = scan_cnt_reg + 1'b1;
        close_res.object_id     = cnt_after_close;
        close_res.object_valid  = 1'b1;
        close_res.nearest_index = IDX_W'(near_idx_reg);
        close_res.min_distance  = near_range_reg;
        close_res.last_of_scan  = 1'b0;

        // empty scan marker carries zero fields
        eos_res.scan_number   = scan_cnt_reg + 1'b1;
        eos_res.object_id     = eos_id;
        eos_res.object_valid  = open_next;
        eos_res.nearest_index = open_next ? IDX_W'(near_idx_next) : '0;
        eos_res.min_distance  = open_next ? near_range_next : '0;
        eos_res.last_of_scan  = 1'b1;

        cmd_push       = accept && (close_obj || end_of_scan);
        cmd_data.two   = close_obj && end_of_scan;
        cmd_data.first = close_obj ? close_res : eos_res;
        cmd_data.second = eos_res;

        prev_range_next = range_mm;
        prev_in_next    = in_range;
        sample_idx_next = (sample_idx_reg == IDX_LAST) ? sample_idx_reg
                                                       : sample_idx_reg + 1'b1;
        obj_cnt_next    = eos_id;
        scan_cnt_next   = scan_cnt_reg;
        if (!end_of_scan)
        begin
            obj_cnt_next = cnt_after_close;
        end
        else
        begin
            prev_range_next = '0;
            prev_in_next    = 1'b0;
            sample_idx_next = '0;
            open_next       = 1'b0;
            near_range_next = '0;
            near_idx_next   = '0;
            obj_cnt_next    = '0;
            scan_cnt_next   = scan_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_range_reg <= '0;
            prev_in_reg    <= 1'b0;
            sample_idx_reg <= '0;
            open_reg       <= 1'b0;
            near_range_reg <= '0;
            near_idx_reg   <= '0;
            obj_cnt_reg    <= '0;
            scan_cnt_reg   <= SCAN_CNT_RST;
        end
        else if (accept)
        begin
            prev_range_reg <= prev_range_next;
            prev_in_reg    <= prev_in_next;
            sample_idx_reg <= sample_idx_next;
            open_reg       <= open_next;
            near_range_reg <= near_range_next;
            near_idx_reg   <= near_idx_next;
            obj_cnt_reg    <= obj_cnt_next;
            scan_cnt_reg   <= scan_cnt_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/rss_back.sv
// rss_back: splits requests into single results, forms the angle and queues
// results for the output; depends on rss_pkg and rss_queue
`default_nettype none

module rss_back
    import rss_pkg::*;
#(
    parameter int OUT_DEPTH = OUT_DEPTH_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire seg_cmd_t          cmd_data,
    input  wire logic              cmd_empty,
    output logic                   cmd_pop,
    input  wire logic [STEP_W-1:0] angle_step,
    input  wire logic              pop,
    output logic                   empty,
    output out_t                   out_data
);

    localparam int LW = $clog2(OUT_DEPTH+1);
    localparam int PW = IDX_W + STEP_W;

    logic          sel_reg, sel_next;
    logic          s1_valid_reg;
    res_t          s1_reg;
    res_t          cur;
    logic          issue;
    logic [LW-1:0] out_level;
    logic [LW:0]   in_flight;
    logic [PW-1:0] product;
    out_t          out_entry;
    logic          out_full;

    always_comb
    begin
        // reserve a slot for what sits in the multiply stage
        in_flight = {1'b0, out_level} + (LW+1)'(s1_valid_reg);
        issue     = !cmd_empty && !out_full && (in_flight < (LW+1)'(OUT_DEPTH));
        cur       = sel_reg ? cmd_data.second : cmd_data.first;
        cmd_pop   = issue && (sel_reg || !cmd_data.two);
        sel_next  = sel_reg;
        if (issue)
        begin
            sel_next = !sel_reg && cmd_data.two;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_reg      <= 1'b0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            sel_reg      <= sel_next;
            s1_valid_reg <= issue;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            s1_reg <= cur;
        end
    end

    always_comb
    begin
        product                = PW'(s1_reg.nearest_index) * PW'(angle_step);
        out_entry.scan_number  = s1_reg.scan_number;
        out_entry.object_id    = s1_reg.object_id;
        out_entry.object_valid = s1_reg.object_valid;
        out_entry.angle        = product[ANGLE_W-1:0];
        out_entry.min_distance = s1_reg.min_distance;
        out_entry.last_of_scan = s1_reg.last_of_scan;
    end

    rss_queue #(
        .W     ($bits(out_t)),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s1_valid_reg),
        .push_data (out_entry),
        .full      (out_full),
        .pop       (pop),
        .pop_data  (out_data),
        .empty     (empty),
        .level     (out_level)
    );

endmodule

`default_nettype wire

>>> rtl/core/range_scan_segmenter_top.sv
// range_scan_segmenter_top: laser scan segmentation by jump distance
// path: results of a sample pass the request queue, the multiply stage register
// and the output queue; a second result of the same sample follows the first
// throughput: one sample per cycle unless the request queue is full; results
// leave at one per cycle when popped, set by the output queue's single write port
// reset: asynchronous, clears all queues and scan state, loads register defaults
`default_nettype none

module range_scan_segmenter_top
    import rss_pkg::*;
#(
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
    parameter int MID_DEPTH   = MID_DEPTH_DEF,
    parameter int OUT_DEPTH   = OUT_DEPTH_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // sample input, queue style
    input  wire logic                 push,
    output logic                      full,
    input  wire logic [RANGE_W-1:0]   range_mm,
    input  wire logic                 end_of_scan,
    // result output, queue style
    output logic                      empty,
    input  wire logic                 pop,
    output logic [SCAN_W-1:0]         scan_number,
    output logic [ID_W-1:0]           object_id,
    output logic                      object_valid,
    output logic [ANGLE_W-1:0]        angle,
    output logic [RANGE_W-1:0]        min_distance,
    output logic                      last_of_scan,
    // register writes
    input  wire logic                 cfg_write,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data
);

    // configuration registers
    logic [RANGE_W-1:0] range_limit_reg;
    logic [RANGE_W-1:0] gap_thresh_reg;
    logic [STEP_W-1:0]  angle_step_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_limit_reg <= RANGE_LIMIT_RST;
            gap_thresh_reg  <= GAP_THRESH_RST;
            angle_step_reg  <= ANGLE_STEP_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_RANGE_LIMIT:   range_limit_reg <= cfg_data;
                CFG_GAP_THRESHOLD: gap_thresh_reg  <= cfg_data;
                CFG_ANGLE_STEP:    angle_step_reg  <= cfg_data;
                default: ;  // writes beyond the register list are dropped
            endcase
        end
    end

    front_cfg_t front_cfg;
    assign front_cfg.range_limit   = range_limit_reg;
    assign front_cfg.gap_threshold = gap_thresh_reg;

    // front: classify each sample against the open object
    logic     cmd_push, cmd_full, cmd_pop, cmd_empty;
    seg_cmd_t cmd_in, cmd_out;

    rss_front #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .range_mm    (range_mm),
        .end_of_scan (end_of_scan),
        .cfg         (front_cfg),
        .cmd_full    (cmd_full),
        .cmd_push    (cmd_push),
        .cmd_data    (cmd_in)
    );

    // input is held off only when the request queue is full
    assign full = cmd_full;

    // request queue decouples the sample stream from result delivery
    rss_queue #(
        .W     ($bits(seg_cmd_t)),
        .DEPTH (MID_DEPTH)
    ) u_cmd_q (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (cmd_push),
        .push_data (cmd_in),
        .full      (cmd_full),
        .pop       (cmd_pop),
        .pop_data  (cmd_out),
        .empty     (cmd_empty),
        .level     ()
    );

    // back: one result per cycle unless the output queue is full, angle multiply, output queue
    out_t res;

    rss_back #(
        .OUT_DEPTH (OUT_DEPTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_data   (cmd_out),
        .cmd_empty  (cmd_empty),
        .cmd_pop    (cmd_pop),
        .angle_step (angle_step_reg),
        .pop        (pop),
        .empty      (empty),
        .out_data   (res)
    );

    assign scan_number  = res.scan_number;
    assign object_id    = res.object_id;
    assign object_valid = res.object_valid;
    assign angle        = res.angle;
    assign min_distance = res.min_distance;
    assign last_of_scan = res.last_of_scan;

endmodule

`default_nettype wire

>>> rtl/core/rss_checker.sv
// rss_checker: port-level assertions on the result stream of the segmenter,
// bound to range_scan_segmenter_top; depends on rss_pkg
`default_nettype none

module rss_checker
    import rss_pkg::*;
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               empty,
    input wire logic               pop,
    input wire logic [SCAN_W-1:0]  scan_number,
    input wire logic [ID_W-1:0]    object_id,
    input wire logic               object_valid,
    input wire logic [ANGLE_W-1:0] angle,
    input wire logic [RANGE_W-1:0] min_distance,
    input wire logic               last_of_scan
);

    // empty scan marker is always the last result of its scan
    a_marker_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !object_valid) |-> last_of_scan)
        else $error("empty scan marker without last mark");

    // empty scan marker carries zero fields
    a_marker_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !object_valid) |->
            (object_id == '0 && angle == '0 && min_distance == '0))
        else $error("empty scan marker with nonzero fields");

    // real objects are numbered from one and have a nonzero range
    a_object_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && object_valid) |-> (object_id != '0 && min_distance != '0))
        else $error("object with zero id or zero distance");

    // a waiting result holds until taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=>
            (!empty && $stable(scan_number) && $stable(object_id)
             && $stable(angle) && $stable(min_distance)))
        else $error("waiting result changed before pop");

endmodule

bind range_scan_segmenter_top rss_checker u_rss_checker (.*);

`default_nettype wire

>>> bench/tb_top.sv
// tb_top: self-checking bench for range_scan_segmenter_top, with a predictor of the
// jump-distance segmentation and field-by-field checks of every result request
// depends on rss_pkg and range_scan_segmenter_top
`default_nettype none

module tb_top;
    import rss_pkg::*;

    // one sample request waiting for the driver
    typedef struct {
        logic [RANGE_W-1:0] r;
        logic               eos;
    } sample_t;

    localparam int PERIOD   = 12;
    localparam int TAIL     = 8;       // cycles after the last result
    localparam int RAND_PER = 210;     // least number of random samples per phase, 8 phases
    localparam int LONG_LEN = 160;     // one long scan of separate objects

    logic                 clk;
    logic                 rst_n;
    logic                 push;
    logic                 full;
    logic [RANGE_W-1:0]   range_mm;
    logic                 end_of_scan;
    logic                 empty;
    logic                 pop;
    logic [SCAN_W-1:0]    scan_number;
    logic [ID_W-1:0]      object_id;
    logic                 object_valid;
    logic [ANGLE_W-1:0]   angle;
    logic [RANGE_W-1:0]   min_distance;
    logic                 last_of_scan;
    logic                 cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    range_scan_segmenter_top u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .range_mm     (range_mm),
        .end_of_scan  (end_of_scan),
        .empty        (empty),
        .pop          (pop),
        .scan_number  (scan_number),
        .object_id    (object_id),
        .object_valid (object_valid),
        .angle        (angle),
        .min_distance (min_distance),
        .last_of_scan (last_of_scan),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // stimulus and expectation stores
    sample_t pending_samples[$];
    out_t    expected_objects[$];
    int      err_count;
    int      send_idle_pct;
    int      recv_stall_pct;
    logic    sample_taken;

    // predictor copy of the registers
    logic [RANGE_W-1:0] lim_mm;
    logic [RANGE_W-1:0] gap_mm;
    logic [STEP_W-1:0]  step_val;

    // predictor copy of the scan state
    logic [RANGE_W-1:0] prev_range;
    logic               prev_in;
    logic [11:0]        samp_idx;
    logic               obj_open;
    logic [RANGE_W-1:0] near_range;
    logic [11:0]        near_idx;
    logic [ID_W-1:0]    obj_cnt;
    logic [SCAN_W-1:0]  scan_cnt;

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    function void clear_scan_state();
        prev_range = '0;
        prev_in    = 1'b0;
        samp_idx   = '0;
        obj_open   = 1'b0;
        near_range = '0;
        near_idx   = '0;
        obj_cnt    = '0;
    endfunction

    // queue one expected object; an invalid one is the empty-scan marker
    function void emit_object(input logic valid, input logic last);
        out_t        o;
        logic [31:0] prod;
        o = '0;
        o.scan_number = scan_cnt + 16'd1;
        if (valid) begin
            // object id sticks at its top value instead of wrapping
            if (obj_cnt < ID_MAX)
                obj_cnt = obj_cnt + 1'b1;
            prod           = 32'(near_idx) * 32'(step_val);
            o.object_id    = obj_cnt;
            o.object_valid = 1'b1;
            o.angle        = prod[ANGLE_W-1:0];
            o.min_distance = near_range;
        end
        o.last_of_scan = last;
        expected_objects.insert(expected_objects.size(), o);
    endfunction

    // one accepted sample: may close an object, and ends the scan on the mark
    function void segment_sample(input logic [RANGE_W-1:0] r, input logic eos);
        logic               in_rng;
        logic [RANGE_W-1:0] diff;
        // zero range is a dropout, not a hit
        in_rng = (r != '0) && (r < lim_mm);
        if (in_rng) begin
            diff = (r >= prev_range) ? r - prev_range : prev_range - r;
            if (obj_open && prev_in && diff < gap_mm) begin
                // first occurrence of the nearest range keeps its index
                if (r < near_range) begin
                    near_range = r;
                    near_idx   = samp_idx;
                end
            end else begin
                if (obj_open)
                    emit_object(1'b1, 1'b0);
                obj_open   = 1'b1;
                near_range = r;
                near_idx   = samp_idx;
            end
        end
        prev_range = r;
        prev_in    = in_rng;
        // index saturates on very long scans
        if (samp_idx < MAX_SAMPLES_DEF - 1)
            samp_idx = samp_idx + 1'b1;
        if (eos) begin
            emit_object(obj_open, 1'b1);
            clear_scan_state();
            scan_cnt = scan_cnt + 1'b1;
        end
    endfunction

    // ------------------------------------------------------------------
    // stimulus generation
    // ------------------------------------------------------------------

    function void add_sample(input int r, input logic eos);
        sample_t s;
        s.r   = r[RANGE_W-1:0];
        s.eos = eos;
        pending_samples.insert(pending_samples.size(), s);
    endfunction

    // a range the block must skip under the current limit
    function int far_range();
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return int'(lim_mm);
            2:       return 65535;
            default: return $urandom_range(int'(lim_mm), 65535);
        endcase
    endfunction

    function int near_hit();
        if (lim_mm <= 16'd1)
            return far_range();
        return $urandom_range(1, int'(lim_mm) - 1);
    endfunction

    function int clamp_hit(input int v);
        if (lim_mm <= 16'd1)
            return v;
        if (v < 1)
            return 1;
        if (v > int'(lim_mm) - 1)
            return int'(lim_mm) - 1;
        return v;
    endfunction

    // one scan worth of samples; returns how many were queued
    function int add_scan();
        int kind;
        int len;
        int cur;
        int nxt;
        int delta;
        int sel;
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
            // noise: any bit pattern, end marks scattered
            len = $urandom_range(1, 12);
            for (int i = 0; i < len; i++)
                add_sample($urandom_range(0, 65535),
                           (i == len - 1) || ($urandom_range(0, 5) == 0));
        end else if (kind == 1) begin
            // nothing in range, scan ends with the marker
            len = $urandom_range(1, 6);
            for (int i = 0; i < len; i++)
                add_sample(far_range(), i == len - 1);
        end else begin
            // clustered returns with jumps, dropouts and edge-of-gap steps
            len = ($urandom_range(0, 19) == 0) ? $urandom_range(40, 150)
                                               : $urandom_range(1, 30);
            cur = near_hit();
            for (int i = 0; i < len; i++) begin
                sel = $urandom_range(0, 99);
                if (sel < 60) begin
                    delta = (gap_mm == '0) ? 0 : $urandom_range(0, int'(gap_mm) - 1);
                    nxt   = clamp_hit($urandom_range(0, 1) ? cur + delta : cur - delta);
                end else if (sel < 70) begin
                    nxt = clamp_hit($urandom_range(0, 1) ? cur + int'(gap_mm)
                                                         : cur - int'(gap_mm));
                end else if (sel < 85) begin
                    nxt = near_hit();
                end else if (sel < 95) begin
                    nxt = -1;
                end else begin
                    nxt = cur;
                end
                if (nxt < 0) begin
                    add_sample(far_range(), i == len - 1);
                end else begin
                    cur = nxt;
                    add_sample(cur, i == len - 1);
                end
            end
        end
        return len;
    endfunction

    // ------------------------------------------------------------------
    // clock, driver and monitor
    // ------------------------------------------------------------------

    initial clk = 1'b0;
    always #(PERIOD / 2) clk = ~clk;

    // sample driver: holds a request until it is taken, idles at random
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            push        <= 1'b0;
            range_mm    <= '0;
            end_of_scan <= 1'b0;
        end else begin
            sample_taken = push && !full;
            if (sample_taken) begin
                segment_sample(range_mm, end_of_scan);
                void'(pending_samples.pop_front());
            end
            // register writes land at the same edge as in the block
            if (cfg_write) begin
                case (cfg_index)
                    CFG_RANGE_LIMIT:   lim_mm   = cfg_data;
                    CFG_GAP_THRESHOLD: gap_mm   = cfg_data;
                    CFG_ANGLE_STEP:    step_val = cfg_data;
                    default:           ;
                endcase
            end
            if (push && !sample_taken) begin
                // request still waiting on full, keep it as is
            end else if (pending_samples.size() != 0 &&
                         $urandom_range(0, 99) >= send_idle_pct) begin
                push        <= 1'b1;
                range_mm    <= pending_samples[0].r;
                end_of_scan <= pending_samples[0].eos;
            end else begin
                push <= 1'b0;
            end
        end
    end

    function void check_field(input string name, input longint exp_v, input longint act_v);
        if (exp_v != act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            err_count++;
        end
    endfunction

    // result monitor: every popped request against the oldest expectation
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (expected_objects.size() == 0) begin
                    $error("result with nothing expected: scan %0d id %0d",
                           scan_number, object_id);
                    err_count++;
                end else begin
                    check_field("scan_number", expected_objects[0].scan_number, scan_number);
                    check_field("object_id", expected_objects[0].object_id, object_id);
                    check_field("object_valid", expected_objects[0].object_valid,
                                object_valid);
                    check_field("angle", expected_objects[0].angle, angle);
                    check_field("min_distance", expected_objects[0].min_distance,
                                min_distance);
                    check_field("last_of_scan", expected_objects[0].last_of_scan,
                                last_of_scan);
                    void'(expected_objects.pop_front());
                end
            end
            pop <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // sequencing
    // ------------------------------------------------------------------

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic set_config(input int lim, input int gap, input int step);
        write_reg(CFG_RANGE_LIMIT, lim[CFG_W-1:0]);
        write_reg(CFG_GAP_THRESHOLD, gap[CFG_W-1:0]);
        write_reg(CFG_ANGLE_STEP, step[CFG_W-1:0]);
    endtask

    // sender holds off until all requests are out and the pipe has settled
    task automatic drain();
        do
            @(negedge clk);
        while (pending_samples.size() != 0 || push || expected_objects.size() != 0);
        repeat (TAIL) @(negedge clk);
    endtask

    task automatic set_idling(input int mode);
        @(negedge clk);
        case (mode)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
            default: begin send_idle_pct = 38; recv_stall_pct = 38; end
        endcase
    endtask

    initial begin
        int queued;
        rst_n          = 1'b0;
        cfg_write      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        err_count      = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        lim_mm         = RANGE_LIMIT_RST;
        gap_mm         = GAP_THRESH_RST;
        step_val       = ANGLE_STEP_RST;
        clear_scan_state();
        scan_cnt       = SCAN_CNT_RST;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // directed part under the reset register values
        @(negedge clk);
        // empty scan gives the invalid marker
        add_sample(0, 1'b1);
        // join, jump, dropout, restart after dropout, limit edge, top range
        add_sample(100, 1'b0);
        add_sample(150, 1'b0);
        add_sample(5000, 1'b0);
        add_sample(0, 1'b0);
        add_sample(5100, 1'b0);
        add_sample(7999, 1'b0);
        add_sample(8000, 1'b0);
        add_sample(65535, 1'b1);
        // step of exactly the gap splits, tie keeps first index,
        // jump on the end mark closes one object and reports another
        add_sample(2000, 1'b0);
        add_sample(3000, 1'b0);
        add_sample(3999, 1'b0);
        add_sample(3000, 1'b0);
        add_sample(2001, 1'b0);
        add_sample(6000, 1'b1);
        // smallest range as a one-sample scan
        add_sample(1, 1'b1);
        add_sample(7999, 1'b0);
        add_sample(7000, 1'b1);
        drain();

        // zero limit: everything is out of range
        set_config(0, 1000, 18350);
        @(negedge clk);
        add_sample(5, 1'b0);
        add_sample(65535, 1'b1);
        drain();
        set_config(1, 1000, 18350);
        @(negedge clk);
        add_sample(1, 1'b1);
        drain();

        // zero gap: equal neighbors still split
        set_config(65535, 0, 65535);
        @(negedge clk);
        add_sample(500, 1'b0);
        add_sample(500, 1'b0);
        add_sample(500, 1'b1);
        // one long scan with the widest step
        for (int i = 0; i < LONG_LEN; i++)
            add_sample($urandom_range(1, 65534), i == LONG_LEN - 1);
        drain();

        // random part: eight phases over the four idling modes
        for (int p = 0; p < 8; p++) begin
            set_idling(p % 4);
            case (p)
                0, 7: set_config(RANGE_LIMIT_RST, GAP_THRESH_RST, ANGLE_STEP_RST);
                1:    set_config($urandom_range(1000, 65535), $urandom_range(1, 4000),
                                 $urandom_range(0, 65535));
                2:    set_config(65535, 65535, 0);
                3:    set_config(200, 1, 1);
                5:    set_config(65535, 0, 65535);
                6:    set_config($urandom_range(2000, 65535), $urandom_range(1, 3000),
                                 $urandom_range(0, 65535));
                default: set_config($urandom_range(0, 65535), $urandom_range(0, 65535),
                                    $urandom_range(0, 65535));
            endcase
            @(negedge clk);
            queued = 0;
            while (queued < RAND_PER)
                queued += add_scan();
            drain();
        end

        if (err_count == 0 && expected_objects.size() == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

    // hang guard, far beyond the slowest legal run
    initial begin
        #(PERIOD * 400000);
        $display("tb_top failed");
        $finish;
    end

endmodule

`default_nettype wire
